@@ src/kcds_pkg.sv @@
package kcds_pkg;

    localparam int CHANNEL_COUNT = 8;
    localparam int KNOB_COUNT    = 6;
    localparam int CHAN_W        = $clog2(CHANNEL_COUNT);
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [7:0]  THRESHOLD_RESET  = 8'd5;
    localparam logic [15:0] IDLE_LIMIT_RESET = 16'd1000;

    localparam logic [CHAN_W-1:0] CH_TONE     = 3'd0;
    localparam logic [CHAN_W-1:0] CH_REVERB   = 3'd1;
    localparam logic [CHAN_W-1:0] CH_TREBLE   = 3'd2;
    localparam logic [CHAN_W-1:0] CH_MIDDLE   = 3'd3;
    localparam logic [CHAN_W-1:0] CH_BASS     = 3'd4;
    localparam logic [CHAN_W-1:0] CH_SENSOR   = 3'd5;
    localparam logic [CHAN_W-1:0] LABEL_FIRST = 3'd6;

    typedef enum logic [1:0] {
        MODE_VALUE = 2'd0,
        MODE_LABEL = 2'd1,
        MODE_IDLE  = 2'd2
    } display_mode_t;

    typedef struct packed {
        logic [7:0] knob0;
        logic [7:0] knob1;
        logic [7:0] knob2;
        logic [7:0] knob3;
        logic [7:0] knob4;
        logic [7:0] knob5;
        logic       button_up;
        logic       button_down;
    } scan_t;

    typedef struct packed {
        display_mode_t      display_mode;
        logic [CHAN_W-1:0]  shown_channel;
        logic signed [7:0]  shown_value;
    } result_t;

    typedef struct packed {
        logic [7:0]  variation_threshold;
        logic [15:0] idle_limit;
    } cfg_t;

endpackage

@@ src/kcds_regs.sv @@
module kcds_regs
    import kcds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    typedef enum logic {
        REG_THRESHOLD  = 1'b0,
        REG_IDLE_LIMIT = 1'b1
    } reg_index_t;

    reg_index_t  index;
    logic        write_en;
    logic [7:0]  threshold_reg;
    logic [15:0] idle_limit_reg;

    assign pready   = 1'b1;
    assign index    = reg_index_t'(paddr[2]);
    assign write_en = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            idle_limit_reg <= IDLE_LIMIT_RESET;
        end
        else if (write_en)
        begin
            case (index)
                REG_THRESHOLD:  threshold_reg  <= pwdata[7:0];
                REG_IDLE_LIMIT: idle_limit_reg <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_THRESHOLD:  prdata = DATA_W'(threshold_reg);
            REG_IDLE_LIMIT: prdata = DATA_W'(idle_limit_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.variation_threshold = threshold_reg;
    assign cfg.idle_limit          = idle_limit_reg;

endmodule

@@ src/kcds_convert.sv @@
module kcds_convert
    import kcds_pkg::*;
(
    input  logic [CHAN_W-1:0] channel,
    input  logic [7:0]        sample,
    output logic signed [7:0] value
);

    localparam logic [20:0] SENSOR_RECIP = 21'd1510705;

    // Exact for dividends below 65280, which covers every use here.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = 17'(x) + 17'(x[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

    logic [7:0]  tone_q;
    logic [7:0]  reverb_q;
    logic [7:0]  eq_q;
    logic [8:0]  tone_val;
    logic [8:0]  eq_val;
    logic [28:0] sensor_prod;
    logic [8:0]  sensor_t;
    logic [7:0]  rescale;
    logic [15:0] rescale_x100;
    logic [7:0]  sensor_q;

    assign tone_q   = div255(16'(sample) * 16'd200);
    assign reverb_q = div255(16'(sample) * 16'd100);
    assign eq_q     = div255(16'(sample) * 16'd12);
    assign tone_val = {1'b0, tone_q} - 9'd100;
    assign eq_val   = {1'b0, eq_q} - 9'd6;

    // The sensor rescale works on floor(255 * s / 177), taken by reciprocal.
    assign sensor_prod = 29'(sample) * 29'(SENSOR_RECIP);
    assign sensor_t    = sensor_prod[28:20];

    always_comb
    begin
        if (sensor_t <= 9'd192)
        begin
            rescale = 8'd0;
        end
        else if (sensor_t >= 9'd256)
        begin
            rescale = 8'd255;
        end
        else
        begin
            rescale = {sensor_t[5:0], 2'b00};
        end
    end

    assign rescale_x100 = (16'(rescale) << 6) + (16'(rescale) << 5) + (16'(rescale) << 2);
    assign sensor_q     = div255(rescale_x100);

    always_comb
    begin
        case (channel) inside
            CH_TONE:              value = tone_val[7:0];
            CH_REVERB:            value = reverb_q;
            [CH_TREBLE:CH_BASS]:  value = eq_val[7:0];
            CH_SENSOR:            value = sensor_q;
            default:              value = '0;
        endcase
    end

endmodule

@@ src/kcds_core.sv @@
module kcds_core
    import kcds_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    scan_valid,
    output logic    scan_ready,
    input  scan_t   scan,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic              scan_valid_reg;
    scan_t             scan_reg;
    logic              result_valid_reg;
    result_t           result_reg;
    result_t           result_next;
    logic [7:0]        prev_samples_reg [KNOB_COUNT];
    logic [CHAN_W-1:0] sel_reg;
    logic [CHAN_W-1:0] sel_next;
    logic [15:0]       idle_count_reg;
    logic [15:0]       idle_count_next;
    logic              prev_up_reg;
    logic              prev_down_reg;

    logic              advance;
    logic [7:0]        knob [KNOB_COUNT];
    logic [KNOB_COUNT-1:0] hit;
    logic              rise_up;
    logic              rise_down;
    logic              pressed;
    logic              changed;
    logic [CHAN_W-1:0] step_ch;
    logic [CHAN_W-1:0] knob_ch;
    logic [7:0]        sample;
    logic signed [7:0] unit_value;

    assign advance    = scan_valid_reg && (!result_valid_reg || result_ready);
    assign scan_ready = !scan_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg <= 1'b0;
        end
        else if (scan_ready)
        begin
            scan_valid_reg <= scan_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_valid && scan_ready)
        begin
            scan_reg <= scan;
        end
    end

    assign knob[0] = scan_reg.knob0;
    assign knob[1] = scan_reg.knob1;
    assign knob[2] = scan_reg.knob2;
    assign knob[3] = scan_reg.knob3;
    assign knob[4] = scan_reg.knob4;
    assign knob[5] = scan_reg.knob5;

    assign rise_up   = scan_reg.button_up && !prev_up_reg;
    assign rise_down = scan_reg.button_down && !prev_down_reg;
    assign pressed   = rise_up || rise_down;
    assign step_ch   = sel_reg + CHAN_W'(rise_up) - CHAN_W'(rise_down);

    always_comb
    begin
        for (int i = 0; i < KNOB_COUNT; i++)
        begin
            if (knob[i] > prev_samples_reg[i])
            begin
                hit[i] = (knob[i] - prev_samples_reg[i]) >= cfg.variation_threshold;
            end
            else
            begin
                hit[i] = (prev_samples_reg[i] - knob[i]) >= cfg.variation_threshold;
            end
        end
    end

    // The lowest knob that moved far enough takes the display.
    always_comb
    begin
        knob_ch = '0;
        for (int i = KNOB_COUNT - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                knob_ch = CHAN_W'(i);
            end
        end
    end

    assign changed  = |hit;
    assign sel_next = changed ? knob_ch : step_ch;

    always_comb
    begin
        if (changed || pressed)
        begin
            idle_count_next = '0;
        end
        else if (idle_count_reg == '1)
        begin
            idle_count_next = idle_count_reg;
        end
        else
        begin
            idle_count_next = idle_count_reg + 16'd1;
        end
    end

    assign sample = (sel_next < CHAN_W'(KNOB_COUNT)) ? knob[sel_next] : 8'd0;

    kcds_convert u_convert (
        .channel (sel_next),
        .sample  (sample),
        .value   (unit_value)
    );

    always_comb
    begin
        result_next.shown_channel = sel_next;
        if (idle_count_next >= cfg.idle_limit)
        begin
            result_next.display_mode = MODE_IDLE;
            result_next.shown_value  = '0;
        end
        else if (sel_next >= LABEL_FIRST)
        begin
            result_next.display_mode = MODE_LABEL;
            result_next.shown_value  = '0;
        end
        else
        begin
            result_next.display_mode = MODE_VALUE;
            result_next.shown_value  = unit_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KNOB_COUNT; i++)
            begin
                prev_samples_reg[i] <= '0;
            end
            sel_reg        <= '0;
            idle_count_reg <= '0;
            prev_up_reg    <= 1'b0;
            prev_down_reg  <= 1'b0;
        end
        else if (advance)
        begin
            for (int i = 0; i < KNOB_COUNT; i++)
            begin
                prev_samples_reg[i] <= knob[i];
            end
            sel_reg        <= sel_next;
            idle_count_reg <= idle_count_next;
            prev_up_reg    <= scan_reg.button_up;
            prev_down_reg  <= scan_reg.button_down;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_value_zero_unless_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.display_mode != MODE_VALUE)
        |-> result_reg.shown_value == 8'sd0)
        else $error("value field not zero outside value mode");

    a_value_mode_knob_only: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.display_mode == MODE_VALUE)
        |-> result_reg.shown_channel < LABEL_FIRST)
        else $error("value mode shown for a label channel");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_reg.shown_channel == sel_reg)
        else $error("shown channel differs from the selection state");

    a_change_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (changed || pressed)) |=> idle_count_reg == 16'd0)
        else $error("idle count not cleared after activity");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !changed && !pressed && idle_count_reg != 16'hFFFF)
        |=> idle_count_reg == $past(idle_count_reg) + 16'd1)
        else $error("idle count did not step by one");

endmodule

@@ src/knob_change_display_selector_unit.sv @@
// Knob change display selector.
// A scan of six knob samples and two button levels enters on the scan channel
// (scan_valid, scan_ready, scan); one result per scan leaves on the result
// channel (result_valid, result_ready, result) with the display mode, the shown
// channel and that channel's value in its unit. A transfer takes place on a
// rising clock edge at which valid and ready are both high.
// A scan is held in an input register, worked through in combinational logic
// and stored in a result register, from which its result is then valid.
// One scan is taken every cycle while results are taken.
// When the receiver stalls, the result register holds its result and the input
// register holds one further scan; scan_ready then falls until the result
// transfer frees the pipeline.
// Reset clears the previous samples, the selected channel, the idle count and
// the button history, empties both registers and restores the threshold to 5
// and the idle limit to 1000. The threshold lies at byte address 0 and the idle
// limit at byte address 4 of the register port, which never waits.
module knob_change_display_selector_unit
    import kcds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              scan_valid,
    output logic              scan_ready,
    input  scan_t             scan,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    cfg_t cfg;

    kcds_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kcds_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .scan_valid   (scan_valid),
        .scan_ready   (scan_ready),
        .scan         (scan),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

@@ bench/kcds_display_checker.sv @@
`timescale 1ns / 100ps

module kcds_display_checker
    import kcds_pkg::*;
#(
    parameter logic [ADDR_W-1:0] THRESHOLD_ADDR  = '0,
    parameter logic [ADDR_W-1:0] IDLE_LIMIT_ADDR = '0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    input  logic              scan_valid,
    input  logic              scan_ready,
    input  scan_t             scan,
    input  logic              result_valid,
    input  logic              result_ready,
    input  result_t           result,
    output int                pending,
    output int                fail_count
);

    logic [7:0]        prev_knob [KNOB_COUNT];
    logic [CHAN_W-1:0] selected;
    logic [15:0]       idle_scans;
    logic              last_up;
    logic              last_down;
    logic [7:0]        min_step;
    logic [15:0]       idle_after;
    result_t           awaited_display [$];
    int                errors;

    function automatic result_t predict_display(input scan_t s);
        logic [7:0]        knob [KNOB_COUNT];
        logic [CHAN_W-1:0] ch;
        logic              pressed;
        logic              moved;
        int                i;
        int                diff;
        int                raw;
        int                level;
        int                val;
        result_t           r;
        knob[0] = s.knob0;
        knob[1] = s.knob1;
        knob[2] = s.knob2;
        knob[3] = s.knob3;
        knob[4] = s.knob4;
        knob[5] = s.knob5;
        ch = selected;
        pressed = 1'b0;
        moved = 1'b0;
        val = 0;
        // The channel index wraps naturally at its width of three bits.
        if (s.button_up && !last_up) begin
            ch = ch + 1'b1;
            pressed = 1'b1;
        end
        if (s.button_down && !last_down) begin
            ch = ch - 1'b1;
            pressed = 1'b1;
        end
        last_up = s.button_up;
        last_down = s.button_down;
        for (i = 0; i < KNOB_COUNT; i++) begin
            diff = int'(knob[i]) - int'(prev_knob[i]);
            if (diff < 0) begin
                diff = -diff;
            end
            if (!moved && diff >= int'(min_step)) begin
                ch = i[CHAN_W-1:0];
                moved = 1'b1;
            end
        end
        if (moved || pressed) begin
            idle_scans = '0;
        end else if (idle_scans != 16'hFFFF) begin
            idle_scans = idle_scans + 1'b1;
        end
        for (i = 0; i < KNOB_COUNT; i++) begin
            prev_knob[i] = knob[i];
        end
        selected = ch;
        if (idle_scans >= idle_after) begin
            r.display_mode = MODE_IDLE;
        end else if (ch >= LABEL_FIRST) begin
            r.display_mode = MODE_LABEL;
        end else begin
            r.display_mode = MODE_VALUE;
            raw = int'(knob[ch]);
            case (ch)
                CH_TONE: val = raw * 200 / 255 - 100;
                CH_REVERB: val = raw * 100 / 255;
                CH_TREBLE, CH_MIDDLE, CH_BASS: val = raw * 12 / 255 - 6;
                CH_SENSOR:
                begin
                    level = 4 * (raw * 255 / 177 - 192);
                    if (level < 0) begin
                        level = 0;
                    end
                    if (level > 255) begin
                        level = 255;
                    end
                    val = level * 100 / 255;
                end
                default: val = 0;
            endcase
        end
        r.shown_channel = ch;
        r.shown_value = val[7:0];
        return r;
    endfunction

    task automatic report_field(input string field, input int want, input int got);
        errors++;
        $display("%0.1f ns: %s expected %0d, got %0d", $realtime, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        int      i;
        if (!rst_n) begin
            for (i = 0; i < KNOB_COUNT; i++) begin
                prev_knob[i] = '0;
            end
            selected = '0;
            idle_scans = '0;
            last_up = 1'b0;
            last_down = 1'b0;
            min_step = THRESHOLD_RESET;
            idle_after = IDLE_LIMIT_RESET;
            awaited_display.delete();
            errors = 0;
            pending <= 0;
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == THRESHOLD_ADDR) begin
                    min_step = pwdata[7:0];
                end else if (paddr == IDLE_LIMIT_ADDR) begin
                    idle_after = pwdata[15:0];
                end
            end
            if (scan_valid && scan_ready) begin
                awaited_display.push_back(predict_display(scan));
            end
            if (result_valid && result_ready) begin
                if (awaited_display.size() == 0) begin
                    report_field("result transfer with no scan waiting, channel", -1,
                                 int'(result.shown_channel));
                end else begin
                    want = awaited_display.pop_front();
                    if (result.display_mode != want.display_mode) begin
                        report_field("display_mode", int'(want.display_mode),
                                     int'(result.display_mode));
                    end
                    if (result.shown_channel != want.shown_channel) begin
                        report_field("shown_channel", int'(want.shown_channel),
                                     int'(result.shown_channel));
                    end
                    if (result.shown_value != want.shown_value) begin
                        report_field("shown_value", int'(want.shown_value),
                                     int'(result.shown_value));
                    end
                end
            end
            pending <= awaited_display.size();
            fail_count <= errors;
        end
    end

endmodule

@@ bench/tb_knob_change_display_selector_unit.sv @@
`timescale 1ns / 100ps

module tb_knob_change_display_selector_unit;
    import kcds_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 12;
    localparam int LONG_HOLD        = 90;
    localparam int SETTLE_CYCLES    = 4;
    localparam int PHASE_SCANS      = 195;
    localparam int TIMEOUT_CYCLES   = 2000000;

    localparam logic [ADDR_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_IDLE_LIMIT = 3'd4;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              scan_valid;
    logic              scan_ready;
    scan_t             scan;
    logic              result_valid;
    logic              result_ready;
    result_t           result;

    int         pending;
    int         fail_count;
    int         burst_left;
    int         gap;
    int         holds_asked;
    int         holds_done;
    logic [7:0] level [KNOB_COUNT];
    logic       up_level;
    logic       down_level;

    knob_change_display_selector_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .scan_valid   (scan_valid),
        .scan_ready   (scan_ready),
        .scan         (scan),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    kcds_display_checker #(
        .THRESHOLD_ADDR  (REG_THRESHOLD),
        .IDLE_LIMIT_ADDR (REG_IDLE_LIMIT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .scan_valid   (scan_valid),
        .scan_ready   (scan_ready),
        .scan         (scan),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

    // The receiver stalls in stretches of changing style; a requested hold-off
    // keeps it from taking any result transfer for a long, counted stretch.
    initial
    begin : receiver
        int stretch;
        int style;
        int hold;
        result_ready = 1'b0;
        stretch = 0;
        style = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold == 0 && holds_done != holds_asked) begin
                hold = LONG_HOLD;
                holds_done++;
            end
            if (stretch == 0) begin
                stretch = $urandom_range(10, 60);
                style = $urandom_range(0, 3);
            end
            stretch--;
            if (hold > 0) begin
                hold--;
                result_ready <= 1'b0;
            end else begin
                case (style)
                    0: result_ready <= 1'b1;
                    1: result_ready <= 1'($urandom_range(0, 1));
                    2: result_ready <= ($urandom_range(0, 3) == 0);
                    default: result_ready <= (stretch % 4 != 0);
                endcase
            end
        end
    end

    function automatic scan_t make_scan(input logic [7:0] k0, input logic [7:0] k1,
                                        input logic [7:0] k2, input logic [7:0] k3,
                                        input logic [7:0] k4, input logic [7:0] k5,
                                        input logic up, input logic down);
        scan_t s;
        s.knob0 = k0;
        s.knob1 = k1;
        s.knob2 = k2;
        s.knob3 = k3;
        s.knob4 = k4;
        s.knob5 = k5;
        s.button_up = up;
        s.button_down = down;
        return s;
    endfunction

    // Mostly small wobbles around the present knob positions, so that the idle
    // count can build up, with single knob moves, fresh settings and extremes.
    function automatic scan_t next_scan();
        int kind;
        int pick;
        int i;
        int v;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, KNOB_COUNT - 1);
        for (i = 0; i < KNOB_COUNT; i++) begin
            if (kind < 55) begin
                v = int'(level[i]) + int'($urandom_range(0, 6)) - 3;
            end else if (kind < 75) begin
                v = (i == pick) ? int'($urandom_range(0, 255)) : int'(level[i]);
            end else if (kind < 90) begin
                v = $urandom_range(0, 255);
            end else begin
                v = $urandom_range(0, 1) ? 255 : 0;
            end
            if (v < 0) begin
                v = 0;
            end
            if (v > 255) begin
                v = 255;
            end
            level[i] = v[7:0];
        end
        if ($urandom_range(0, 5) == 0) begin
            up_level = ~up_level;
        end
        if ($urandom_range(0, 5) == 0) begin
            down_level = ~down_level;
        end
        return make_scan(level[0], level[1], level[2], level[3], level[4], level[5],
                         up_level, down_level);
    endfunction

    task automatic offer(input scan_t s);
        scan <= s;
        scan_valid <= 1'b1;
        do
            @(posedge clk);
        while (!scan_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                scan_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_for_results();
        scan_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Unused upper bits of each register write carry random noise.
    task automatic set_display_config(input logic [7:0] threshold, input logic [15:0] limit);
        logic [DATA_W-1:0] data;
        wait_for_results();
        data = $urandom();
        data[7:0] = threshold;
        write_reg(REG_THRESHOLD, data);
        data = $urandom();
        data[15:0] = limit;
        write_reg(REG_IDLE_LIMIT, data);
    endtask

    initial
    begin : stimulus
        int phase;
        int n;
        int i;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        scan_valid = 1'b0;
        scan = '0;
        burst_left = 0;
        gap = 0;
        holds_asked = 0;
        holds_done = 0;
        up_level = 1'b0;
        down_level = 1'b0;
        for (i = 0; i < KNOB_COUNT; i++) begin
            level[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed scans under the reset settings.
        offer(make_scan(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd4, 8'd0, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd9, 8'd0, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd9, 8'd255, 8'd140, 1'b0, 1'b0));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd9, 8'd255, 8'd255, 1'b0, 1'b0));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b1, 1'b0));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b1, 1'b1));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b1, 1'b1));
        offer(make_scan(8'd255, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd0, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b1, 1'b0));
        offer(make_scan(8'd0, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b0, 1'b1));
        offer(make_scan(8'd0, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b1, 1'b0));
        offer(make_scan(8'd0, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b0, 1'b0));

        set_display_config(8'd0, 16'd0);
        offer(make_scan(8'd0, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd1, 8'd254, 8'd3, 8'd9, 8'd250, 8'd0, 1'b1, 1'b0));
        offer(make_scan(8'd0, 8'd255, 8'd0, 8'd9, 8'd255, 8'd0, 1'b0, 1'b0));

        set_display_config(8'd255, 16'd2);
        offer(make_scan(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd0, 8'd255, 8'd0, 8'd254, 8'd255, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd0, 8'd255, 8'd0, 8'd254, 8'd255, 8'd0, 1'b0, 1'b0));
        offer(make_scan(8'd0, 8'd255, 8'd0, 8'd254, 8'd255, 8'd0, 1'b0, 1'b0));
        for (i = 0; i < KNOB_COUNT; i++) begin
            level[i] = 8'd128;
        end

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_display_config(8'd5, 16'd12);
                1: set_display_config(8'd0, 16'd0);
                2: set_display_config(8'd255, 16'hFFFF);
                3: set_display_config(8'd1, 16'd3);
                4: set_display_config(8'($urandom_range(0, 40)), 16'($urandom_range(1, 64)));
                5: set_display_config(8'($urandom_range(0, 255)),
                                      16'($urandom_range(0, 65535)));
                6: set_display_config(8'd8, 16'd30);
                default: set_display_config(8'($urandom_range(0, 12)),
                                            16'($urandom_range(0, 20)));
            endcase
            for (n = 0; n < PHASE_SCANS; n++) begin
                if (phase == 2 && n == 40) begin
                    holds_asked++;
                end
                if (phase == 4 && n == 100) begin
                    wait_for_results();
                end
                offer(next_scan());
            end
        end

        wait_for_results();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
